// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros - concurrent assertion helpers
// clocked assertions with an active-low reset disable, compiled out by ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: src/cpff_pkg.sv
// ----------------------------------------------------------------------------
// cpff_pkg - channel packet filter shared definitions
// types, register map and frame layout constants
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpff_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 4;
  localparam int unsigned NUM_IDS          = 4;
  localparam int unsigned ID_W             = 16;
  localparam int unsigned COUNT_W          = 3;
  localparam int unsigned WORD_W           = 32;
  localparam int unsigned LEN_W            = 30;
  localparam int unsigned MIX_W            = 2;
  localparam int unsigned APB_DW           = 32;
  localparam int unsigned APB_AW           = 5;
  localparam int unsigned REG_IDX_W        = 3;

  localparam logic [ID_W-1:0] TYPE_BASE_HI = 16'h55AA;
  localparam int unsigned HDR_MIX_LSB  = 13;
  localparam int unsigned HDR_CNT_LSB  = 10;
  localparam int unsigned LEN_INIT_BIT = 31;

  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ID0   = 3'd0,
    REG_ID1   = 3'd1,
    REG_ID2   = 3'd2,
    REG_ID3   = 3'd3,
    REG_COUNT = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_LENGTH  = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_e;

  typedef struct packed {
    logic [NUM_IDS-1:0][ID_W-1:0] id;
    logic [COUNT_W-1:0]           count;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    kind_e             kind;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// File: src/cpff_regs.sv
// ----------------------------------------------------------------------------
// cpff_regs - configuration register file
// apb-style write and read of channel ids and channel count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpff_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [cpff_pkg::APB_AW-1:0]  paddr_i,
  input  logic [cpff_pkg::APB_DW-1:0]  pwdata_i,
  output logic [cpff_pkg::APB_DW-1:0]  prdata_o,
  output cpff_pkg::cfg_t               cfg_o
);
  import cpff_pkg::*;

  logic [NUM_IDS-1:0][ID_W-1:0] id_q;
  logic [COUNT_W-1:0]           count_q;
  logic                         wr_en;
  reg_idx_e                     idx;

  assign wr_en = psel_i & penable_i & pwrite_i;
  assign idx   = reg_idx_e'(paddr_i[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q    <= '0;
      count_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ID0:   id_q[0] <= pwdata_i[ID_W-1:0];
        REG_ID1:   id_q[1] <= pwdata_i[ID_W-1:0];
        REG_ID2:   id_q[2] <= pwdata_i[ID_W-1:0];
        REG_ID3:   id_q[3] <= pwdata_i[ID_W-1:0];
        REG_COUNT: count_q <= pwdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ID0:   prdata_o = APB_DW'(id_q[0]);
      REG_ID1:   prdata_o = APB_DW'(id_q[1]);
      REG_ID2:   prdata_o = APB_DW'(id_q[2]);
      REG_ID3:   prdata_o = APB_DW'(id_q[3]);
      REG_COUNT: prdata_o = APB_DW'(count_q);
      default:   prdata_o = '0;
    endcase
  end

  assign cfg_o.id    = id_q;
  assign cfg_o.count = count_q;

endmodule

`default_nettype wire

// File: src/cpff_front.sv
// ----------------------------------------------------------------------------
// cpff_front - frame word classifier
// tracks the word position, matches the type word and builds forward requests
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpff_front #(
  parameter int unsigned MAX_CHANNELS = cpff_pkg::MAX_CHANNELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cpff_pkg::cfg_t               cfg_i,
  input  logic                         accept_i,
  input  logic                         op_i,
  input  logic                         start_i,
  input  logic [cpff_pkg::WORD_W-1:0]  word_i,
  output logic                         res_valid_o,
  output cpff_pkg::res_t               res_o
);
  import cpff_pkg::*;

  localparam logic [2:0] POS_IDLE    = 3'd0;
  localparam logic [2:0] POS_W1      = 3'd1;
  localparam logic [2:0] POS_W2      = 3'd2;
  localparam logic [2:0] POS_W3      = 3'd3;
  localparam logic [2:0] POS_W4      = 3'd4;
  localparam logic [2:0] POS_W5      = 3'd5;
  localparam logic [2:0] POS_W6      = 3'd6;
  localparam logic [2:0] POS_PAYLOAD = 3'd7;

  logic [2:0]       pos_q, pos_d;
  logic [MIX_W-1:0] mix_q, mix_d;
  logic [LEN_W-1:0] remain_q, remain_d;
  logic             init_q, init_d;
  logic             hit;
  logic [MIX_W-1:0] hit_idx;
  logic [LEN_W-1:0] len4;

  // lowest matching channel wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = MAX_CHANNELS - 1; k >= 0; k--) begin
      if ((COUNT_W'(k) < cfg_i.count) && (word_i == {TYPE_BASE_HI, cfg_i.id[k]})) begin
        hit     = 1'b1;
        hit_idx = MIX_W'(k);
      end
    end
  end

  assign len4 = word_i[WORD_W-1:2];

  always_comb begin
    pos_d       = pos_q;
    mix_d       = mix_q;
    remain_d    = remain_q;
    init_d      = init_q;
    res_valid_o = 1'b0;
    res_o.word  = word_i;
    res_o.kind  = KIND_PAYLOAD;
    res_o.last  = 1'b0;
    if (accept_i) begin
      if (op_i) begin
        init_d = 1'b1;
      end else if (start_i) begin
        pos_d    = POS_W1;
        mix_d    = '0;
        remain_d = '0;
      end else begin
        unique case (pos_q) inside
          POS_IDLE: ;
          POS_W1, POS_W2: pos_d = pos_q + 3'd1;
          POS_W3: begin
            if (hit) begin
              pos_d = POS_W4;
              mix_d = hit_idx;
            end else begin
              pos_d  = POS_IDLE;
              init_d = 1'b0;
            end
          end
          POS_W4: begin
            pos_d       = POS_W5;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_HEADER;
            res_o.word  = word_i | (WORD_W'(mix_q) << HDR_MIX_LSB)
                                 | (WORD_W'(cfg_i.count) << HDR_CNT_LSB);
          end
          POS_W5: pos_d = POS_W6;
          POS_W6: begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_LENGTH;
            res_o.word  = WORD_W'(len4) | (WORD_W'(init_q) << LEN_INIT_BIT);
            init_d      = 1'b0;
            if (len4 == '0) begin
              res_o.last = 1'b1;
              pos_d      = POS_IDLE;
            end else begin
              remain_d = len4;
              pos_d    = POS_PAYLOAD;
            end
          end
          POS_PAYLOAD: begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_PAYLOAD;
            remain_d    = remain_q - LEN_W'(1);
            if (remain_q == LEN_W'(1)) begin
              res_o.last = 1'b1;
              pos_d      = POS_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_IDLE;
      mix_q    <= '0;
      remain_q <= '0;
      init_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      mix_q    <= mix_d;
      remain_q <= remain_d;
      init_q   <= init_d;
    end
  end

endmodule

`default_nettype wire

// File: src/cpff_fifo.sv
// ----------------------------------------------------------------------------
// cpff_fifo - request queue
// short queue between the classifier and the output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpff_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cpff_pkg::res_t  data_i,
  input  logic            pop_i,
  output cpff_pkg::res_t  data_o,
  output logic            empty_o,
  output logic            full_o
);
  import cpff_pkg::*;

  res_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/cpff_back.sv
// ----------------------------------------------------------------------------
// cpff_back - output stage
// registered master stream stage fed from the request queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpff_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  cpff_pkg::res_t               q_data_i,
  output logic                         q_pop_o,
  output logic                         tvalid_o,
  input  logic                         tready_i,
  output logic [cpff_pkg::WORD_W-1:0]  tdata_o,
  output logic [1:0]                   tuser_o,
  output logic                         tlast_o
);
  import cpff_pkg::*;

  logic valid_q;
  res_t data_q;

  assign q_pop_o = !q_empty_i && (!valid_q || tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || tready_i) begin
      valid_q <= !q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= q_data_i;
    end
  end

  assign tvalid_o = valid_q;
  assign tdata_o  = data_q.word;
  assign tuser_o  = data_q.kind;
  assign tlast_o  = data_q.last;

endmodule

`default_nettype wire

// File: src/channel_packet_filter_forwarder.sv
// ----------------------------------------------------------------------------
// channel_packet_filter_forwarder - channel packet filter and forwarder
// filters received frames by channel id and forwards header, length and payload
// ----------------------------------------------------------------------------
//  channel   dir  data                               user / last
//  s_axis    in   tdata: frame_word[31:0]            tuser: operation[0], frame_start[1]
//  m_axis    out  tdata: out_word[31:0]              tuser: out_kind[1:0], tlast: out_last
//  apb       in   5 registers at byte address 4*i    write on psel & penable & pwrite
//
//  one request per cycle while s_axis_tready is high; the classifier is combinational
//  into a two-entry queue, followed by the registered output stage
//  s_axis_tready falls only while the queue is full (output stalled)
//  reset is asynchronous, active low, and clears all control state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module channel_packet_filter_forwarder #(
  parameter int unsigned MAX_CHANNELS = cpff_pkg::MAX_CHANNELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpff_pkg::APB_AW-1:0]  paddr,
  input  logic [cpff_pkg::APB_DW-1:0]  pwdata,
  output logic [cpff_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [cpff_pkg::WORD_W-1:0]  s_axis_tdata,   // frame_word
  input  logic [1:0]                   s_axis_tuser,   // operation, frame_start
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [cpff_pkg::WORD_W-1:0]  m_axis_tdata,   // out_word
  output logic [1:0]                   m_axis_tuser,   // out_kind
  output logic                         m_axis_tlast
);
  import cpff_pkg::*;

  cfg_t cfg;
  logic s_accept;
  logic res_valid;
  res_t res;
  logic q_push, q_pop, q_empty, q_full;
  res_t q_data;

  assign pready        = 1'b1;
  assign s_axis_tready = !q_full;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign q_push        = res_valid;

  cpff_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  cpff_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (s_accept),
    .op_i        (s_axis_tuser[0]),
    .start_i     (s_axis_tuser[1]),
    .word_i      (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cpff_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (res),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  cpff_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .tvalid_o  (m_axis_tvalid),
    .tready_i  (m_axis_tready),
    .tdata_o   (m_axis_tdata),
    .tuser_o   (m_axis_tuser),
    .tlast_o   (m_axis_tlast)
  );

`include "assert_macros.svh"

  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, q_push && q_full)
  `ASSERT_NEVER(a_reinit_silent, clk_i, rst_ni, s_accept && s_axis_tuser[0] && res_valid)
  `ASSERT_NEVER(a_hdr_not_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast && (m_axis_tuser == KIND_HEADER))
  `ASSERT_AT(a_pop_has_data, clk_i, rst_ni, q_pop |-> !q_empty)

endmodule

`default_nettype wire
